// File: rtl/pid_tw_pkg.sv
// Package with shared types, constants and command structs for the PID twiddle block.
`timescale 1ns / 1ps
package pid_tw_pkg;

    localparam int TUNE_WINDOW = 100;
    localparam int TUNE_PERIOD = 2 * TUNE_WINDOW;
    localparam int CNT_W = 16;
    localparam int GAIN_W = 24;
    localparam int ERR_W = 16;
    localparam int SUM_W = 40;
    localparam int SQ_W = 48;
    localparam int TOL_W = 15;
    localparam int RATE_W = 16;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP_P = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP_D = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP_I = 3'd5;
    localparam logic [IDX_W-1:0] REG_TOL    = 3'd6;
    localparam logic [IDX_W-1:0] REG_RATE   = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV,
        ST_ADD,
        ST_SUB,
        ST_BACK,
        ST_SCALE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUMUP,
        ST_OUT
    } pid_state_t;

    typedef struct packed {
        logic       load;      // capture input, update error sum and square sum
        logic       div_start;
        logic       gain_add;
        logic       gain_sub;
        logic       gain_back;
        logic       step_scale;
        logic [1:0] sel;       // which gain/step is updated
        logic       mul0;
        logic       mul1;
        logic       mul2;
        logic       mul3;
        logic       sumup;
        logic       finish;    // bump counter, load output register
        logic       tune_end;  // clear counter and square sum
    } pid_cmd_t;

    typedef struct packed {
        logic tune;
        logic div_done;
        logic better;
        logic big_err;
    } pid_stat_t;

endpackage

// File: rtl/pid_with_twiddle_tuning_top.sv
// Top level of the PID controller with twiddle gain tuning.
// A sample is taken only in idle, so one item is finished before the next is accepted;
// a tuning sample adds the 48-step divider and the three gain updates, each through the
// add, subtract, optional back-off and scale states.
// Reset: gains and steps return to their reset values, sums clear, counter goes to one.
// The output register lets the next item be accepted while a result waits.
`timescale 1ns / 1ps
module pid_with_twiddle_tuning_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [pid_tw_pkg::ERR_W-1:0] error_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] steer,
    output logic        tuned,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pid_tw_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import pid_tw_pkg::*;

    pid_cmd_t  cmd;
    pid_stat_t stat;
    logic      idle;
    logic      out_valid_reg;

    pid_tw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_busy (out_valid_reg && out_stall),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle)
    );

    pid_tw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .error_sample (error_sample),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_idx      (cfg_index),
        .cfg_data     (cfg_data),
        .steer_val    (steer),
        .tuned_val    (tuned)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign cfg_ready = idle;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && out_stall))
        else $error("result overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> idle)
        else $error("input taken while busy");

endmodule

// File: rtl/pid_tw_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module pid_tw_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pid_tw_pkg::SQ_W-1:0]  dividend,
    input  logic [pid_tw_pkg::CNT_W-1:0] divisor,
    output logic                        done,
    output logic [pid_tw_pkg::SQ_W-1:0]  quotient
);
    import pid_tw_pkg::*;

    localparam int BCNT_W = $clog2(SQ_W + 1);

    logic [SQ_W-1:0]   quo_reg, quo_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [BCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[CNT_W-1:0], quo_reg[SQ_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = (divisor == '0) ? CNT_W'(1) : divisor;
            cnt_next  = BCNT_W'(SQ_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[SQ_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - BCNT_W'(1);
            if (cnt_reg == BCNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == BCNT_W'(1));
    assign quotient = quo_next;

    // The remainder always stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < {1'b0, dvs_reg}))
        else $error("divider remainder out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg)
        else $error("divider did not stop");

endmodule

// File: rtl/pid_tw_ctrl.sv
// Sequencer that steps the datapath through one sample and an optional tuning pass.
`timescale 1ns / 1ps
module pid_tw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  out_busy,
    input  pid_tw_pkg::pid_stat_t stat,
    output pid_tw_pkg::pid_cmd_t  cmd,
    output logic                  idle
);
    import pid_tw_pkg::*;

    pid_state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                sel_next = '0;
                if (stat.tune)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_MUL0;
            end
            ST_DIV:
                if (stat.div_done)
                    state_next = ST_ADD;
            ST_ADD:
            begin
                cmd.gain_add = 1'b1;
                state_next   = ST_SUB;
            end
            ST_SUB:
            begin
                if (stat.better)
                    cmd.step_scale = 1'b1;
                else
                    cmd.gain_sub = 1'b1;
                state_next = stat.better ? ST_SCALE : ST_BACK;
            end
            ST_BACK:
            begin
                if (!stat.big_err)
                    cmd.gain_back = 1'b1;
                cmd.step_scale = 1'b1;
                state_next     = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (sel_reg == 2'd2)
                begin
                    cmd.tune_end = 1'b1;
                    state_next   = ST_MUL0;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_ADD;
                end
            end
            ST_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = ST_SUMUP;
            end
            ST_SUMUP:
            begin
                cmd.sumup  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_IDLE))
        else $error("finish did not return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_ACCUM))
        else $error("load not followed by accumulate");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (sel_reg != 2'd3))
        else $error("gain select out of range");

endmodule

// File: rtl/pid_tw_dp.sv
// Datapath: error state, gains and steps, squared error sum, drive computation.
`timescale 1ns / 1ps
module pid_tw_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pid_tw_pkg::pid_cmd_t          cmd,
    output pid_tw_pkg::pid_stat_t         stat,
    input  logic signed [pid_tw_pkg::ERR_W-1:0] error_sample,
    input  logic                          cfg_we,
    input  logic [pid_tw_pkg::IDX_W-1:0]  cfg_idx,
    input  logic [31:0]                   cfg_data,
    output logic signed [15:0]            steer_val,
    output logic                          tuned_val
);
    import pid_tw_pkg::*;

    localparam logic signed [GAIN_W-1:0] G_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] G_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam int ACC_W = 68;
    localparam int PH_W = $clog2(TUNE_PERIOD);
    localparam int ES_LO_W = 20;

    logic signed [GAIN_W-1:0] gain_reg [3];
    logic signed [GAIN_W-1:0] step_reg [3];
    logic [TOL_W-1:0]  tol_reg;
    logic [RATE_W-1:0] rate_reg;
    logic signed [ERR_W-1:0] last_reg, e_reg;
    logic signed [ERR_W:0]   diff_reg;
    logic signed [SUM_W-1:0] esum_reg;
    logic [SQ_W-1:0] sq_reg, best_reg, mean_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PH_W-1:0] phase_reg;
    logic tune_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_reg;

    logic div_done;
    logic [SQ_W-1:0] quo;

    pid_tw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sq_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quo)
    );

    function automatic logic signed [GAIN_W-1:0] sat_g(input logic signed [GAIN_W+1:0] v);
        if (v > $signed({{2{G_MAX[GAIN_W-1]}}, G_MAX}))
            return G_MAX;
        else if (v < $signed({{2{G_MIN[GAIN_W-1]}}, G_MIN}))
            return G_MIN;
        else
            return v[GAIN_W-1:0];
    endfunction

    // Current gain and step under update.
    logic signed [GAIN_W-1:0] g_cur, s_cur;
    logic signed [GAIN_W+1:0] g_ext, s_ext;
    logic [RATE_W:0] factor;
    logic signed [GAIN_W+RATE_W+1:0] scaled;
    logic signed [GAIN_W+1:0] scaled_sh;
    logic signed [SUM_W:0] esum_wide;
    logic signed [2*ERR_W-1:0] sq_s;
    logic [SQ_W:0] sq_wide;
    logic [ERR_W-1:0] mag;
    logic signed [ACC_W-1:0] neg_acc;
    logic signed [ACC_W-1:0] one_q28;
    logic signed [GAIN_W+ERR_W-1:0] prod_p;
    logic signed [GAIN_W+ERR_W:0] prod_d;
    logic signed [GAIN_W+ES_LO_W:0] prod_il;
    logic signed [GAIN_W+SUM_W-ES_LO_W-1:0] prod_ih;

    always_comb
    begin
        g_cur  = gain_reg[cmd.sel];
        s_cur  = step_reg[cmd.sel];
        g_ext  = {{2{g_cur[GAIN_W-1]}}, g_cur};
        s_ext  = {{2{s_cur[GAIN_W-1]}}, s_cur};
        factor = (cmd.step_scale && (stat.better || stat.big_err || !cmd.gain_back)
                  && !cmd.gain_back) ? ({1'b1, {RATE_W{1'b0}}} + {1'b0, rate_reg})
                 : ({1'b1, {RATE_W{1'b0}}} - {1'b0, rate_reg});
        scaled    = s_cur * $signed({1'b0, factor});
        scaled_sh = scaled[GAIN_W+RATE_W+1:RATE_W];
        esum_wide = {esum_reg[SUM_W-1], esum_reg} + {{(SUM_W-ERR_W+1){error_sample[ERR_W-1]}},
                    error_sample};
        sq_s      = error_sample * error_sample;
        sq_wide   = {1'b0, sq_reg} + {{(SQ_W-2*ERR_W+1){1'b0}}, sq_s};
        mag       = e_reg[ERR_W-1] ? ERR_W'(-e_reg) : e_reg;
        neg_acc   = -acc_reg;
        one_q28   = ACC_W'(64'sd268435456);
        // The integral term is split into two narrow products, taken in the mul2 and mul3 steps.
        prod_p    = gain_reg[0] * e_reg;
        prod_d    = gain_reg[1] * diff_reg;
        prod_il   = gain_reg[2] * $signed({1'b0, esum_reg[ES_LO_W-1:0]});
        prod_ih   = gain_reg[2] * $signed(esum_reg[SUM_W-1:ES_LO_W]);
    end

    assign stat.tune     = tune_reg;
    assign stat.div_done = div_done;
    assign stat.better   = (mean_reg < best_reg);
    assign stat.big_err  = ({1'b0, mag} > {2'b0, tol_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[0] <= GAIN_W'(13107);
            gain_reg[1] <= GAIN_W'(196608);
            gain_reg[2] <= GAIN_W'(262);
            step_reg[0] <= GAIN_W'(655);
            step_reg[1] <= GAIN_W'(6554);
            step_reg[2] <= GAIN_W'(65);
            tol_reg   <= TOL_W'(819);
            rate_reg  <= RATE_W'(6554);
            last_reg  <= '0;
            esum_reg  <= '0;
            sq_reg    <= '0;
            best_reg  <= '1;
            cnt_reg   <= CNT_W'(1);
            phase_reg <= PH_W'(1);
            tune_reg  <= 1'b0;
            tuned_val <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_GAIN_P, REG_GAIN_D, REG_GAIN_I:
                        gain_reg[cfg_idx[1:0]] <= cfg_data[GAIN_W-1:0];
                    REG_STEP_P, REG_STEP_D, REG_STEP_I:
                        step_reg[2'(cfg_idx - REG_STEP_P)] <= cfg_data[GAIN_W-1:0];
                    REG_TOL:  tol_reg  <= cfg_data[TOL_W-1:0];
                    REG_RATE: rate_reg <= cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                last_reg <= error_sample;
                if (esum_wide > $signed({S_MAX[SUM_W-1], S_MAX}))
                    esum_reg <= S_MAX;
                else if (esum_wide < $signed({S_MIN[SUM_W-1], S_MIN}))
                    esum_reg <= S_MIN;
                else
                    esum_reg <= esum_wide[SUM_W-1:0];
                // The phase counter follows the sample counter modulo the tuning period.
                tune_reg <= (phase_reg == '0);
                if (cnt_reg >= CNT_W'(TUNE_WINDOW))
                    sq_reg <= sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];
            end
            if (cmd.gain_add)
                gain_reg[cmd.sel] <= sat_g(g_ext + s_ext);
            if (cmd.gain_sub)
                gain_reg[cmd.sel] <= sat_g(g_ext - (s_ext <<< 1));
            if (cmd.gain_back)
                gain_reg[cmd.sel] <= sat_g(g_ext + s_ext);
            if (cmd.step_scale)
            begin
                step_reg[cmd.sel] <= sat_g(scaled_sh);
                if (stat.better && !cmd.gain_back)
                    best_reg <= mean_reg;
            end
            if (cmd.tune_end)
            begin
                cnt_reg   <= '0;
                phase_reg <= '0;
                sq_reg    <= '0;
            end
            if (cmd.finish)
            begin
                cnt_reg   <= cnt_reg + CNT_W'(1);
                tuned_val <= tune_reg;
                if (cnt_reg == '1 || phase_reg == PH_W'(TUNE_PERIOD - 1))
                    phase_reg <= '0;
                else
                    phase_reg <= phase_reg + PH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg    <= error_sample;
            diff_reg <= {error_sample[ERR_W-1], error_sample} - {last_reg[ERR_W-1], last_reg};
        end
        if (div_done)
            mean_reg <= quo;
        if (cmd.mul0)
        begin
            prod_reg <= ACC_W'(prod_p);
            acc_reg  <= '0;
        end
        if (cmd.mul1)
        begin
            prod_reg <= ACC_W'(prod_d);
            acc_reg  <= acc_reg + prod_reg;
        end
        if (cmd.mul2)
        begin
            prod_reg <= ACC_W'(prod_il);
            acc_reg  <= acc_reg + prod_reg;
        end
        if (cmd.mul3)
        begin
            prod_reg <= ACC_W'(prod_ih) <<< ES_LO_W;
            acc_reg  <= acc_reg + prod_reg;
        end
        if (cmd.sumup)
            acc_reg <= acc_reg + prod_reg;
        if (cmd.finish)
        begin
            if (neg_acc >= one_q28)
                steer_val <= 16'sd16384;
            else if (neg_acc <= -one_q28)
                steer_val <= -16'sd16384;
            else
                steer_val <= 16'(neg_acc >>> 14);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tune_end |=> (cnt_reg == '0 && sq_reg == '0))
        else $error("tuning pass did not clear counter");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (tuned_val == $past(tune_reg)))
        else $error("tuned flag mismatch");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.gain_add && cmd.gain_sub) == 1'b0)
        else $error("conflicting gain updates");

endmodule

// File: sim/pid_with_twiddle_tuning_top_tb.sv
// Self-checking testbench for the PID controller with twiddle gain tuning.
`timescale 1ns / 1ps
module pid_with_twiddle_tuning_top_tb;
    import pid_tw_pkg::*;

    localparam longint G_MAX = 64'sd8388607;
    localparam longint G_MIN = -64'sd8388608;
    localparam longint SUM_MAX = 64'sd549755813887;
    localparam longint SUM_MIN = -64'sd549755813888;
    localparam longint SQ_MAX = 64'hFFFF_FFFF_FFFF;
    localparam longint ONE_Q28 = 64'sd268435456;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] steer;
        logic               tuned;
    } drive_t;

    // Scoreboard: a predictor of the control law and the tuning pass, plus the
    // queue of drive values still owed by the block.
    class pid_scoreboard;
        longint gain_init [3];
        longint step_init [3];
        longint tol;
        longint rate_q16;
        longint prev_err;
        longint err_acc;
        longint gain [3];
        longint step [3];
        longint sq_acc;
        longint best;
        longint count;
        drive_t pending [$];
        int     mismatches;

        function new();
            gain_init = '{13107, 196608, 262};
            step_init = '{655, 6554, 65};
            tol = 819;
            rate_q16 = 6554;
            for (int i = 0; i < 3; i++)
            begin
                gain[i] = gain_init[i];
                step[i] = step_init[i];
            end
            prev_err = 0;
            err_acc = 0;
            sq_acc = 0;
            best = SQ_MAX;
            count = 1;
            mismatches = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint scale(longint s, longint factor);
            return clip((s * factor) >>> 16, G_MIN, G_MAX);
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
            longint v;
            v = longint'(signed'(data[23:0]));
            case (idx)
                REG_GAIN_P, REG_GAIN_D, REG_GAIN_I:
                begin
                    gain_init[idx] = v;
                    gain[idx] = v;
                end
                REG_STEP_P, REG_STEP_D, REG_STEP_I:
                begin
                    step_init[idx - REG_STEP_P] = v;
                    step[idx - REG_STEP_P] = v;
                end
                REG_TOL:  tol = data[14:0];
                REG_RATE: rate_q16 = data[15:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [15:0] sample);
            longint e, diff, acc, mean, mag;
            drive_t d;
            bit tune;
            e = sample;
            diff = e - prev_err;
            prev_err = e;
            err_acc = clip(err_acc + e, SUM_MIN, SUM_MAX);
            tune = (count % TUNE_PERIOD) == 0;
            if (count >= TUNE_WINDOW)
            begin
                sq_acc = sq_acc + e * e;
                if (sq_acc > SQ_MAX)
                    sq_acc = SQ_MAX;
            end
            if (tune)
            begin
                mean = sq_acc / (count == 0 ? 1 : count);
                mag = e < 0 ? -e : e;
                for (int i = 0; i < 3; i++)
                begin
                    gain[i] = clip(gain[i] + step[i], G_MIN, G_MAX);
                    if (mean < best)
                    begin
                        best = mean;
                        step[i] = scale(step[i], 65536 + rate_q16);
                    end
                    else
                    begin
                        gain[i] = clip(gain[i] - 2 * step[i], G_MIN, G_MAX);
                        if (mag > tol)
                            step[i] = scale(step[i], 65536 + rate_q16);
                        else
                        begin
                            gain[i] = clip(gain[i] + step[i], G_MIN, G_MAX);
                            step[i] = scale(step[i], 65536 - rate_q16);
                        end
                    end
                end
                count = 0;
                sq_acc = 0;
            end
            acc = -(gain[0] * e + gain[1] * diff + gain[2] * err_acc);
            if (acc >= ONE_Q28)
                d.steer = 16384;
            else if (acc <= -ONE_Q28)
                d.steer = -16384;
            else
                d.steer = 16'(acc >>> 14);
            d.tuned = tune;
            count = (count + 1) & 16'hFFFF;
            pending.push_back(d);
        endfunction

        task check_drive(logic signed [15:0] got_steer, logic got_tuned);
            drive_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("drive value with no sample waiting", 0, got_steer);
                return;
            end
            want = pending.pop_front();
            if (got_steer !== want.steer)
                report_mismatch("steer", want.steer, got_steer);
            if (got_tuned !== want.tuned)
                report_mismatch("tuned", want.tuned, got_tuned);
        endtask

        task report_mismatch(string what, longint want, longint got);
            mismatches++;
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [ERR_W-1:0] error_sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] steer;
    logic tuned;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    pid_scoreboard sb = new();
    bit quiet = 1'b0;         // no random idling on either side
    int hold_off = 0;         // long receiver stall, counted in cycles
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    always #5 clk = ~clk;

    pid_with_twiddle_tuning_top dut (.*);

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.note_sample(error_sample);
        if (out_valid && !out_stall)
            sb.check_drive(steer, tuned);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver side: random stalls, or a held stall when hold_off is set.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                hold_off = hold_off - 1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 37);
        end
    end

    // Valid stays high between back-to-back transfers; idle gaps and drain lower it.
    task automatic send_sample(logic signed [15:0] value);
        while (!quiet && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        error_sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_err(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(1600))) - 16'sd800;
            default: return $signed(16'($urandom_range(12000))) - 16'sd6000;
        endcase
    endfunction

    // Gains, steps, tolerance and rate used over the phases, the extremes among them.
    task automatic load_setting(int phase);
        case (phase)
            0:
            begin
                write_cfg(REG_GAIN_P, 32'h7FFFFF);
                write_cfg(REG_GAIN_D, 32'h800000);
                write_cfg(REG_GAIN_I, 32'h7FFFFF);
                write_cfg(REG_STEP_P, 32'h7FFFFF);
                write_cfg(REG_STEP_D, 32'h800000);
                write_cfg(REG_STEP_I, 32'h000000);
                write_cfg(REG_TOL, 32'h7FFF);
                write_cfg(REG_RATE, 32'hFFFF);
            end
            1:
            begin
                write_cfg(REG_GAIN_P, 32'd20000);
                write_cfg(REG_GAIN_D, 32'd100000);
                write_cfg(REG_GAIN_I, 32'd0);
                write_cfg(REG_STEP_P, 32'd3000);
                write_cfg(REG_STEP_D, 32'hFFF000);
                write_cfg(REG_STEP_I, 32'd50);
                write_cfg(REG_TOL, 32'd0);
                write_cfg(REG_RATE, 32'd0);
            end
            default:
            begin
                for (int r = 0; r < 6; r++)
                    write_cfg(r[IDX_W-1:0], $urandom);
                write_cfg(REG_TOL, $urandom_range(32767));
                write_cfg(REG_RATE, $urandom_range(65535));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic signed [15:0] edge_vals [8];
        edge_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                      16'sh0001, 16'sh8000, 16'sh7FFF, 16'sh0333};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Extremes and sign flips under reset gains.
        foreach (edge_vals[k])
            send_sample(edge_vals[k]);
        drain();

        // Saturating settings with alternating full-scale errors.
        load_setting(0);
        for (int k = 0; k < 14; k++)
            send_sample(k[0] ? 16'sh8000 : 16'sh7FFF);
        drain();

        // Long receiver hold-off while the sender keeps offering samples.
        hold_off = 300;
        for (int k = 0; k < 40; k++)
            send_sample(rand_err(0));
        drain();

        // Setting phases, one fixed and the rest random, each long enough to cross at least one tuning pass.
        for (int phase = 1; phase < 7; phase++)
        begin
            load_setting(phase);
            quiet = (phase == 3);
            for (int k = 0; k < 215; k++)
                send_sample(rand_err($urandom_range(2)));
            drain();
        end
        quiet = 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
